// File: src/cmbb_pkg.sv
// ----------------------------------------------------------------------------
// cmbb_pkg
// Shared codes for the column-major bit blitter.
// ----------------------------------------------------------------------------
package cmbb_pkg;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_BLIT  = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SRC_START = 3'd1;
  localparam logic [2:0] ST_DST       = 3'd2;
  localparam logic [2:0] ST_SRC_RANGE = 3'd3;
  localparam logic [2:0] ST_SKIPPED   = 3'd4;

  localparam logic [12:0] LIMIT_RESET = 13'd4096;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_CHECK = 7'b0010000,
    S_RD    = 7'b0100000,
    S_WR    = 7'b1000000
  } state_t;

endpackage

// File: src/cmbb_ram.sv
// ----------------------------------------------------------------------------
// cmbb_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cmbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/column_major_bit_blitter.sv
// ----------------------------------------------------------------------------
// column_major_bit_blitter
// Monochrome bit blit from a source bitmap into a column-major frame.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) takes one command transaction: load a
// source byte, write or read a frame byte, or blit a block. Each command
// gives one result transaction (read_data, status) on out_valid/out_stall.
// cfg_valid/cfg_ready writes source_limit_bytes; cfg_ready is always high.
// Load and write: the result is registered and shows in the cycle after
// accept. Read: the frame byte is registered in S_READ. Blit: S_DIV splits
// the destination start into column and row (reciprocal multiply, then one
// correction step), S_CHECK checks it, then each copied bit of the clipped
// block takes S_RD (frame and source read) and S_WR (frame byte write back).
// A rejected or empty blit answers from S_CHECK, a skipped one on accept.
// One command is in flight at a time; a new command is taken while the
// previous result is being taken in the same cycle.
// Reset clears all FRAME_BYTES frame bytes (4096 by default) with a pass of
// one byte a cycle, during which in_stall stays high. The source memory is
// not cleared.
// While out_stall holds a result, in_stall is high and the result holds.
// ----------------------------------------------------------------------------
module column_major_bit_blitter #(
  parameter int COLUMN_BITS  = 128,
  parameter int COLUMN_COUNT = 256,
  parameter int SOURCE_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [11:0] byte_address,
  input  logic [7:0]  byte_data,
  input  logic [15:0] src_start_bit,
  input  logic [15:0] dst_start_bit,
  input  logic [8:0]  block_width,
  input  logic [7:0]  block_height,
  input  logic        invert,
  input  logic        pad_enable,
  input  logic        pad_color,
  input  logic        last_in_list,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data,
  output logic [2:0]  status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data
);

  localparam int FRAME_BYTES = (COLUMN_BITS * COLUMN_COUNT + 7) / 8;
  localparam int FA_W = $clog2(FRAME_BYTES);
  localparam int SA_W = $clog2(SOURCE_BYTES);
  localparam int RW = $clog2(COLUMN_BITS) + 1;
  localparam int CW = RW + 8;
  localparam int BIT_W = $clog2(65536 + 512 * (COLUMN_BITS + 8));
  localparam int BYTE_W = BIT_W - 3;
  localparam int RECIP_SH = 24;
  localparam logic [21:0] RECIP = 22'((1 << RECIP_SH) / COLUMN_BITS);

  cmbb_pkg::state_t state;

  logic [12:0]       limit;
  logic              aborted;
  logic [FA_W-1:0]   clr_addr;

  logic [15:0]       ss;
  logic [15:0]       ds;
  logic [15:0]       dq;
  logic [13:0]       qe;
  logic [8:0]        bw;
  logic [7:0]        bh;
  logic              inv;
  logic              pad;
  logic              color;
  logic              last;
  logic              rd_ok;
  logic              div_cnt;
  logic [RW-1:0]     rem;
  logic [16:0]       prod;

  logic [8:0]        wc;
  logic [7:0]        hc;
  logic [8:0]        stride;
  logic [8:0]        j;
  logic [7:0]        k;
  logic [BIT_W-1:0]  sbase;
  logic [BIT_W-1:0]  dbase;
  logic              src_oob;

  logic              fr_we;
  logic [FA_W-1:0]   fr_waddr;
  logic [7:0]        fr_wdata;
  logic [FA_W-1:0]   fr_raddr;
  logic [7:0]        fr_rdata;
  logic              sr_we;
  logic [SA_W-1:0]   sr_raddr;
  logic [7:0]        sr_rdata;

  logic              accept;
  logic              out_free;
  logic [37:0]       qprod;
  logic [15:0]       qc;
  logic [15:0]       rdiff;
  logic [BIT_W-1:0]  sbit;
  logic [BIT_W-1:0]  dbit;
  logic [BYTE_W-1:0] sbyte;
  logic [BYTE_W-1:0] dbyte;
  logic              bitv;
  logic [7:0]        mask;
  logic [15:0]       limit_bits;
  logic [20:0]       range_sum;
  logic [16:0]       col_ext;
  logic [2:0]        chk_status;

  assign cfg_ready = 1'b1;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != cmbb_pkg::S_IDLE) || !out_free;
  assign accept = in_valid && !in_stall;

  // column estimate is exact or one low
  assign qprod = 38'(ds) * 38'(RECIP);
  assign qc = 16'(32'(qe) * COLUMN_BITS);
  assign rdiff = ds - qc;
  assign sbit = sbase + BIT_W'(k);
  assign dbit = dbase + BIT_W'(k);
  assign sbyte = sbit[BIT_W-1:3];
  assign dbyte = dbit[BIT_W-1:3];
  assign mask = 8'h80 >> dbit[2:0];
  assign bitv = pad ? color : ((sr_rdata[3'd7 - sbit[2:0]] & !src_oob) ^ inv);
  assign limit_bits = {limit, 3'b000};
  assign range_sum = 21'(ss) + {1'b0, prod, 3'b000};
  assign col_ext = {1'b0, dq};

  always_comb begin
    if (ss >= limit_bits) begin
      chk_status = cmbb_pkg::ST_SRC_START;
    end else if (col_ext > 17'(COLUMN_COUNT)) begin
      chk_status = cmbb_pkg::ST_DST;
    end else if (range_sum >= 21'(limit_bits)) begin
      chk_status = cmbb_pkg::ST_SRC_RANGE;
    end else begin
      chk_status = cmbb_pkg::ST_OK;
    end
  end

  always_comb begin
    fr_we = 1'b0;
    fr_waddr = clr_addr;
    fr_wdata = 8'd0;
    fr_raddr = FA_W'(byte_address);
    sr_we = 1'b0;
    sr_raddr = SA_W'(sbyte);
    case (state)
      cmbb_pkg::S_CLEAR: begin
        fr_we = 1'b1;
      end
      cmbb_pkg::S_IDLE: begin
        if (accept && cmd == cmbb_pkg::CMD_WRITE &&
            17'(byte_address) < 17'(FRAME_BYTES)) begin
          fr_we = 1'b1;
          fr_waddr = FA_W'(byte_address);
          fr_wdata = byte_data;
        end
        if (accept && cmd == cmbb_pkg::CMD_LOAD &&
            17'(byte_address) < 17'(SOURCE_BYTES)) begin
          sr_we = 1'b1;
        end
      end
      cmbb_pkg::S_RD: begin
        fr_raddr = FA_W'(dbyte);
      end
      cmbb_pkg::S_WR: begin
        fr_raddr = FA_W'(dbyte);
        fr_waddr = FA_W'(dbyte);
        fr_wdata = bitv ? (fr_rdata | mask) : (fr_rdata & ~mask);
        fr_we = (BYTE_W + 1)'(dbyte) < (BYTE_W + 1)'(FRAME_BYTES);
      end
      default: begin
      end
    endcase
  end

  cmbb_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame (
    .clk   (clk),
    .we    (fr_we),
    .waddr (fr_waddr),
    .wdata (fr_wdata),
    .raddr (fr_raddr),
    .rdata (fr_rdata)
  );

  cmbb_ram #(.WIDTH(8), .DEPTH(SOURCE_BYTES)) u_source (
    .clk   (clk),
    .we    (sr_we),
    .waddr (SA_W'(byte_address)),
    .wdata (byte_data),
    .raddr (sr_raddr),
    .rdata (sr_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cmbb_pkg::S_CLEAR;
      clr_addr <= '0;
      limit <= cmbb_pkg::LIMIT_RESET;
      aborted <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        limit <= cfg_data;
      end
      if (out_valid && !out_stall && !accept) begin
        out_valid <= 1'b0;
      end
      case (state)
        cmbb_pkg::S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == FA_W'(FRAME_BYTES - 1)) begin
            state <= cmbb_pkg::S_IDLE;
          end
        end
        cmbb_pkg::S_IDLE: begin
          if (accept) begin
            ss <= src_start_bit;
            ds <= dst_start_bit;
            bw <= block_width;
            bh <= block_height;
            inv <= invert;
            pad <= pad_enable;
            color <= pad_color;
            last <= last_in_list;
            rd_ok <= 17'(byte_address) < 17'(FRAME_BYTES);
            rem <= '0;
            div_cnt <= 1'b0;
            read_data <= 8'd0;
            status <= cmbb_pkg::ST_OK;
            case (cmd)
              cmbb_pkg::CMD_READ: begin
                out_valid <= 1'b0;
                state <= cmbb_pkg::S_READ;
              end
              cmbb_pkg::CMD_BLIT: begin
                if (aborted) begin
                  status <= cmbb_pkg::ST_SKIPPED;
                  out_valid <= 1'b1;
                  if (last_in_list) begin
                    aborted <= 1'b0;
                  end
                end else begin
                  out_valid <= 1'b0;
                  state <= cmbb_pkg::S_DIV;
                end
              end
              default: begin
                out_valid <= 1'b1;
              end
            endcase
            src_oob <= 1'b0;
          end
        end
        cmbb_pkg::S_READ: begin
          read_data <= rd_ok ? fr_rdata : 8'd0;
          out_valid <= 1'b1;
          state <= cmbb_pkg::S_IDLE;
        end
        cmbb_pkg::S_DIV: begin
          div_cnt <= 1'b1;
          if (!div_cnt) begin
            prod <= bw * bh;
            qe <= qprod[RECIP_SH+13:RECIP_SH];
          end else begin
            if (rdiff >= 16'(COLUMN_BITS)) begin
              dq <= 16'(qe) + 16'd1;
              rem <= RW'(rdiff - 16'(COLUMN_BITS));
            end else begin
              dq <= 16'(qe);
              rem <= RW'(rdiff);
            end
            state <= cmbb_pkg::S_CHECK;
          end
        end
        cmbb_pkg::S_CHECK: begin
          wc <= (col_ext + 17'(bw) > 17'(COLUMN_COUNT)) ?
                9'(17'(COLUMN_COUNT) - col_ext) : bw;
          hc <= (CW'(rem) + CW'(bh) > CW'(COLUMN_BITS)) ?
                8'(RW'(COLUMN_BITS) - rem) : bh;
          stride <= (((CW'(rem) + CW'(bh) > CW'(COLUMN_BITS)) ?
                     9'(8'(RW'(COLUMN_BITS) - rem)) : 9'(bh)) + 9'd7) & 9'h1F8;
          sbase <= BIT_W'(ss);
          dbase <= BIT_W'(ds);
          j <= '0;
          k <= '0;
          if (chk_status != cmbb_pkg::ST_OK || col_ext == 17'(COLUMN_COUNT) ||
              bw == 9'd0 || bh == 8'd0 || rem == RW'(COLUMN_BITS)) begin
            status <= chk_status;
            out_valid <= 1'b1;
            state <= cmbb_pkg::S_IDLE;
            aborted <= (chk_status != cmbb_pkg::ST_OK) && !last;
          end else begin
            state <= cmbb_pkg::S_RD;
          end
        end
        cmbb_pkg::S_RD: begin
          src_oob <= (BYTE_W + 1)'(sbyte) >= (BYTE_W + 1)'(SOURCE_BYTES);
          state <= cmbb_pkg::S_WR;
        end
        cmbb_pkg::S_WR: begin
          if (k == hc - 8'd1) begin
            k <= '0;
            j <= j + 9'd1;
            sbase <= sbase + BIT_W'(stride);
            dbase <= dbase + BIT_W'(COLUMN_BITS);
            if (j == wc - 9'd1) begin
              status <= cmbb_pkg::ST_OK;
              out_valid <= 1'b1;
              state <= cmbb_pkg::S_IDLE;
              if (last) begin
                aborted <= 1'b0;
              end
            end else begin
              state <= cmbb_pkg::S_RD;
            end
          end else begin
            k <= k + 8'd1;
            state <= cmbb_pkg::S_RD;
          end
        end
        default: begin
          state <= cmbb_pkg::S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_clear_stalls: assert property (@(posedge clk) disable iff (rst)
    state == cmbb_pkg::S_CLEAR |-> in_stall)
    else $error("input taken during frame clear");
  a_blit_data_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != cmbb_pkg::ST_OK |-> read_data == 8'd0)
    else $error("blit result carries read data");
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= cmbb_pkg::ST_SKIPPED)
    else $error("status code out of range");
  a_wr_next: assert property (@(posedge clk) disable iff (rst)
    state == cmbb_pkg::S_WR |=> state == cmbb_pkg::S_RD || state == cmbb_pkg::S_IDLE)
    else $error("bad step after write back");
`endif

endmodule
